/* rtl/hfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_pkg
// Shared sizes, types and codes of the frame packer with timeout flush.
// ----------------------------------------------------------------------------
package hfp_pkg;

   localparam int RING_DEPTH    = 256;
   localparam int FRAME_PAYLOAD = 63;
   localparam int PTR_W         = $clog2(RING_DEPTH);
   localparam int IDX_W         = $clog2(FRAME_PAYLOAD + 1);
   localparam int BYTE_W        = 8;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic CSR_IDX_FLUSH_TIMEOUT = 1'b0;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } ctrl_state_type;

   typedef struct packed {
      logic              valid;
      logic              use_ram;
      logic [BYTE_W-1:0] const_byte;
      logic              last;
   } issue_type;

endpackage

/* rtl/hfp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_req_if / hfp_rsp_if
// Valid/ready channels for queued input transactions and frame bytes.
// ----------------------------------------------------------------------------
interface hfp_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [hfp_pkg::BYTE_W-1:0] data_byte;
   logic                      burst_end;

   modport source (output valid, output op, output data_byte, output burst_end,
                   input ready);
   modport sink   (input valid, input op, input data_byte, input burst_end,
                   output ready);
endinterface

interface hfp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hfp_pkg::BYTE_W-1:0] out_byte;
   logic                      frame_last;

   modport source (output valid, output out_byte, output frame_last, input ready);
   modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface

/* rtl/hfp_ring_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_ring_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hfp_ring_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/hfp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_ctrl
// Pointer, wait counter and frame sequencer; issues ring reads one byte a cycle while the output pipe can take them.
// ----------------------------------------------------------------------------
module hfp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   hfp_req_if.sink                      req,
   input  logic [hfp_pkg::BYTE_W-1:0]   flush_timeout,
   input  logic                         can_issue,
   output hfp_pkg::issue_type           issue,
   output logic                         wr_en,
   output logic [hfp_pkg::PTR_W-1:0]    wr_addr,
   output logic [hfp_pkg::BYTE_W-1:0]   wr_data,
   output logic                         rd_en,
   output logic [hfp_pkg::PTR_W-1:0]    rd_addr
);

   hfp_pkg::ctrl_state_type state_ff, state_in;

   logic [hfp_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [hfp_pkg::PTR_W-1:0]  rp_ff, rp_in;
   logic [hfp_pkg::BYTE_W-1:0] wait_ff, wait_in;
   logic [hfp_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [hfp_pkg::BYTE_W-1:0] cnt_ff, cnt_in;
   logic                       full_ff, full_in;

   logic [hfp_pkg::PTR_W-1:0]  pending;
   logic [hfp_pkg::BYTE_W-1:0] wait_inc;
   logic                       accept;
   logic                       is_tick;
   logic                       has_full;
   logic                       start_full;
   logic                       start_flush;
   logic                       idx_last;
   logic                       issue_go;

   assign pending     = wp_ff - rp_ff;
   assign wait_inc    = wait_ff + 1'b1;
   assign accept      = req.valid && req.ready;
   assign is_tick     = (req.op == hfp_pkg::OP_TICK);
   assign has_full    = 32'(pending) >= 32'(hfp_pkg::FRAME_PAYLOAD);
   assign start_full  = accept && is_tick && has_full;
   assign start_flush = accept && is_tick && !has_full && (pending != '0) &&
                        (wait_inc == flush_timeout);
   assign idx_last    = (32'(idx_ff) == 32'(hfp_pkg::FRAME_PAYLOAD));
   assign issue_go    = (state_ff == hfp_pkg::ST_SEND) && can_issue;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hfp_pkg::ST_IDLE: begin
            if (start_full || start_flush) begin
               state_in = hfp_pkg::ST_SEND;
            end
         end
         hfp_pkg::ST_SEND: begin
            if (issue_go && idx_last) begin
               state_in = hfp_pkg::ST_IDLE;
            end
         end
         default: state_in = hfp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready        = 1'b0;
      issue.valid      = 1'b0;
      issue.use_ram    = 1'b0;
      issue.const_byte = '0;
      issue.last       = idx_last;
      unique case (state_ff)
         hfp_pkg::ST_IDLE: begin
            req.ready = 1'b1;
         end
         hfp_pkg::ST_SEND: begin
            issue.valid = can_issue;
            if (idx_ff == '0) begin
               issue.const_byte = cnt_ff;
            end else if (hfp_pkg::BYTE_W'(idx_ff) <= cnt_ff) begin
               issue.use_ram = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign wr_en   = accept && (req.op == hfp_pkg::OP_PUSH);
   assign wr_addr = wp_ff;
   assign wr_data = req.data_byte;
   assign rd_en   = issue.valid && issue.use_ram;
   assign rd_addr = rp_ff + hfp_pkg::PTR_W'(idx_ff) - 1'b1;

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      wait_in = wait_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      full_in = full_ff;
      if (wr_en) begin
         wp_in = wp_ff + 1'b1;
      end
      if (start_full) begin
         wait_in = '0;
         idx_in  = '0;
         cnt_in  = hfp_pkg::BYTE_W'(hfp_pkg::FRAME_PAYLOAD);
         full_in = 1'b1;
      end else if (start_flush) begin
         wait_in = '0;
         idx_in  = '0;
         cnt_in  = hfp_pkg::BYTE_W'(pending);
         full_in = 1'b0;
      end else if (accept && is_tick && (pending != '0)) begin
         wait_in = wait_inc;
      end
      if (issue_go) begin
         idx_in = idx_ff + 1'b1;
         if (idx_last) begin
            rp_in = full_ff ? rp_ff + hfp_pkg::PTR_W'(hfp_pkg::FRAME_PAYLOAD) : wp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hfp_pkg::ST_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         wait_ff  <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      full_ff <= full_in;
   end

endmodule

/* rtl/hfp_out_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_out_pipe
// Aligns issued bytes with the RAM read latency and holds the output register.
// ----------------------------------------------------------------------------
module hfp_out_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  hfp_pkg::issue_type         issue,
   input  logic [hfp_pkg::BYTE_W-1:0] rd_data,
   output logic                       can_issue,
   hfp_rsp_if.source                  rsp
);

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_use_ram_ff;
   logic [hfp_pkg::BYTE_W-1:0] s1_const_ff;
   logic                       s1_last_ff;

   logic                       out_valid_ff, out_valid_in;
   logic [hfp_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_free;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign can_issue = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         out_byte_in  = s1_use_ram_ff ? rd_data : s1_const_ff;
         out_last_in  = s1_last_ff;
         s1_valid_in  = 1'b0;
      end
      if (issue.valid) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         s1_use_ram_ff <= issue.use_ram;
         s1_const_ff   <= issue.const_byte;
         s1_last_ff    <= issue.last;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.frame_last = out_last_ff;

endmodule

/* rtl/hid_frame_packer_timeout_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_frame_packer_timeout_unit
// Queues bytes in a ring RAM and packs them into count-prefixed frames.
//
//   Channel   Direction  Transaction
//   req_bus   in         push a byte (op 0) or send tick (op 1)
//   rsp_bus   out        one frame byte, frame_last on the final byte
//   csr_*     in/out     APB-style register port, flush_timeout at 0x0
//
// A push or a tick that sends nothing leaves input ready. A tick that sends a
// frame holds off input while the sequencer reads the ring RAM, one byte per
// cycle through its single read port while the output can take the bytes.
// Output stalls back up into the sequencer and hold off input for longer.
// Reset is synchronous, clears pointers and wait counter and sets the register
// to TIMEOUT_RESET (5); no clearing pass is needed.
// ----------------------------------------------------------------------------
module hid_frame_packer_timeout_unit (
   input  logic                                clock,
   input  logic                                reset,
   hfp_req_if.sink                             req_bus,
   hfp_rsp_if.source                           rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hfp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hfp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hfp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [hfp_pkg::BYTE_W-1:0] timeout_ff, timeout_in;
   logic                       csr_write;

   hfp_pkg::issue_type         issue;
   logic                       can_issue;
   logic                       wr_en;
   logic [hfp_pkg::PTR_W-1:0]  wr_addr;
   logic [hfp_pkg::BYTE_W-1:0] wr_data;
   logic                       rd_en;
   logic [hfp_pkg::PTR_W-1:0]  rd_addr;
   logic [hfp_pkg::BYTE_W-1:0] rd_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write && (csr_paddr[2] == hfp_pkg::CSR_IDX_FLUSH_TIMEOUT)) begin
         timeout_in = csr_pwdata[hfp_pkg::BYTE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         hfp_pkg::CSR_IDX_FLUSH_TIMEOUT: begin
            csr_prdata = hfp_pkg::CSR_DATA_W'(timeout_ff);
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= hfp_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   hfp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .flush_timeout (timeout_ff),
      .can_issue     (can_issue),
      .issue         (issue),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   hfp_ring_ram #(
      .DEPTH (hfp_pkg::RING_DEPTH),
      .WIDTH (hfp_pkg::BYTE_W)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hfp_out_pipe u_out_pipe (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rd_data   (rd_data),
      .can_issue (can_issue),
      .rsp       (rsp_bus)
   );

endmodule

/* rtl/hfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfp_checker
// Port-level checks of the frame packer, bound to the top level.
// ----------------------------------------------------------------------------
module hfp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [hfp_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                       rsp_frame_last
);

   // A stalled frame byte must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_frame_last))
      else $error("frame byte changed while stalled");

   // Reset leaves no frame byte pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("frame byte valid after reset");

   // Once a frame has started, its bytes follow without gaps.
   a_frame_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_frame_last |=> rsp_valid)
      else $error("gap inside a frame");

endmodule

bind hid_frame_packer_timeout_unit hfp_checker u_hfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_out_byte   (rsp_bus.out_byte),
   .rsp_frame_last (rsp_bus.frame_last)
);
